@@ design/assert_macros.svh @@
// Assertion macros used by lsct_datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/lsct_pkg.sv @@
`default_nettype none
package lsct_pkg;

	// Table geometry.
	localparam int NUM_SEGMENTS   = 1024;
	localparam int SEGMENT_BLOCKS = 256;
	localparam int SEG_AW         = $clog2(NUM_SEGMENTS);
	localparam int SEG_SHIFT      = $clog2(SEGMENT_BLOCKS);
	localparam int CNT_W          = 11;
	localparam int LIVE_W         = 8;
	localparam int TIME_W         = 32;
	localparam int PCT_W          = 7;
	localparam int BLK_W          = 18;
	localparam int IDX_W          = 2;
	localparam int ENTRY_W        = 2 + LIVE_W + TIME_W;
	localparam logic [LIVE_W-1:0] LIVE_MAX = LIVE_W'(SEGMENT_BLOCKS - 1);

	// Segment states.
	localparam logic [1:0] SEG_FREE = 2'd0;
	localparam logic [1:0] SEG_FULL = 2'd2;

	// Result status codes.
	localparam logic [1:0] RES_OK       = 2'd0;
	localparam logic [1:0] RES_RANGE    = 2'd1;
	localparam logic [1:0] RES_NOT_FULL = 2'd2;

	// Register indexes.
	localparam logic [IDX_W-1:0] REG_SEGS     = 2'd0;
	localparam logic [IDX_W-1:0] REG_LOW_FREE = 2'd1;
	localparam logic [IDX_W-1:0] REG_MAX_LIVE = 2'd2;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_MARK    = 2'd1,
		OP_SELECT  = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ITEM_RD,
		S_ITEM_WB,
		S_SCAN_RD,
		S_SCAN_MUL1,
		S_SCAN_MUL2,
		S_SCAN_CMP,
		S_SCAN_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        state;
		logic [LIVE_W-1:0] live;
		logic [TIME_W-1:0] wtime;
	} entry_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic clr_step;
		logic rd_scan;
		logic item_wb;
		logic mul1;
		logic mul2;
		logic cmp;
		logic scan_done;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic clr_last;
		logic scan_last;
		logic cfg_clear;
	} sts_t;

endpackage
`default_nettype wire

@@ design/lsct_ram.sv @@
`default_nettype none
module lsct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ design/lsct_ctrl.sv @@
`default_nettype none
module lsct_ctrl
	import lsct_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] op,
	input  wire sts_t       sts,
	output cmd_t            cmd,
	output logic            busy
);

	state_t state_q, state_d;

	// State register; reset starts with a clearing pass over the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (op == OP_SELECT) ? S_SCAN_RD : S_ITEM_RD;
				end
			end
			S_ITEM_RD: begin
				state_d = S_ITEM_WB;
			end
			S_ITEM_WB: begin
				cmd.item_wb = 1'b1;
				state_d     = S_IDLE;
			end
			S_SCAN_RD: begin
				cmd.rd_scan = 1'b1;
				state_d     = S_SCAN_MUL1;
			end
			S_SCAN_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_SCAN_MUL2;
			end
			S_SCAN_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				cmd.cmp = 1'b1;
				state_d = sts.scan_last ? S_SCAN_DONE : S_SCAN_RD;
			end
			S_SCAN_DONE: begin
				cmd.scan_done = 1'b1;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		// A write of the segment count restarts the clearing pass.
		if (sts.cfg_clear) begin
			state_d = S_CLEAR;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

@@ design/lsct_datapath.sv @@
`include "assert_macros.svh"
`default_nettype none
module lsct_datapath
	import lsct_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [CNT_W-1:0]  cfg_data,
	input  wire logic [1:0]        op,
	input  wire logic [SEG_AW-1:0] segment,
	input  wire logic [BLK_W-1:0]  block_addr,
	input  wire logic [1:0]        entry_state,
	input  wire logic [LIVE_W-1:0] entry_live,
	input  wire logic [TIME_W-1:0] entry_time,
	input  wire logic [TIME_W-1:0] now,
	output logic                   done,
	output logic [1:0]             status,
	output logic                   victim_valid,
	output logic [SEG_AW-1:0]      victim_segment,
	output logic                   gc_needed,
	output logic [CNT_W-1:0]       free_count,
	output logic [LIVE_W-1:0]      live_after
);

	localparam int AGE_W = TIME_W;
	localparam int P1_W  = AGE_W + LIVE_W;
	localparam int P2_W  = P1_W + LIVE_W + 1;
	localparam int PW    = 16;
	localparam int GW    = 18;

	// Configuration and free counter.
	logic [CNT_W-1:0] segs_q, free_q, cnt;
	logic [PCT_W-1:0] low_q, maxp_q;
	logic             cfg_clear;

	assign cfg_clear = cfg_we && (cfg_index == REG_SEGS);

	// Segment count clamped to the range from 1 to the table size.
	always_comb begin
		if (segs_q == '0) begin
			cnt = CNT_W'(1);
		end else if (segs_q > CNT_W'(NUM_SEGMENTS)) begin
			cnt = CNT_W'(NUM_SEGMENTS);
		end else begin
			cnt = segs_q;
		end
	end

	function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (v > CNT_W'(NUM_SEGMENTS)) begin
			r = CNT_W'(NUM_SEGMENTS);
		end
		return r;
	endfunction

	// Captured item.
	logic [1:0]        op_q;
	logic [SEG_AW-1:0] seg_q;
	logic [BLK_W-1:0]  blk_q;
	logic [1:0]        est_q;
	logic [LIVE_W-1:0] elive_q;
	logic [TIME_W-1:0] etime_q, now_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			seg_q   <= segment;
			blk_q   <= block_addr;
			est_q   <= entry_state;
			elive_q <= entry_live;
			etime_q <= entry_time;
			now_q   <= now;
		end
	end

	// Table memory.
	logic              ram_we;
	logic [SEG_AW-1:0] ram_waddr, ram_raddr, item_addr;
	entry_t            ram_wdata, rd;
	logic [ENTRY_W-1:0] ram_rdata;

	lsct_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_SEGMENTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd = entry_t'(ram_rdata);

	// Clearing pass and scan counters.
	logic [SEG_AW-1:0] clr_idx_q, scan_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cfg_clear) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_step) begin
			clr_idx_q <= clr_idx_q + SEG_AW'(1);
		end
	end

	assign sts.clr_last  = (clr_idx_q == SEG_AW'(NUM_SEGMENTS - 1));
	assign sts.scan_last = ({1'b0, scan_idx_q} == (cnt - CNT_W'(1)));
	assign sts.cfg_clear = cfg_clear;

	// Item address and range check.
	logic [BLK_W-1:0] mark_seg;
	logic             in_range;

	assign mark_seg  = blk_q >> SEG_SHIFT;
	assign item_addr = (op_q == OP_MARK) ? mark_seg[SEG_AW-1:0] : seg_q;
	assign in_range  = (op_q == OP_MARK) ? (mark_seg < BLK_W'(cnt))
	                                     : ({1'b0, seg_q} < cnt);
	assign ram_raddr = cmd.rd_scan ? scan_idx_q : item_addr;

	// Read-modify-write of one entry.
	logic              item_we;
	entry_t            item_wdata;
	logic [CNT_W-1:0]  free_next;
	logic [1:0]        item_status;
	logic [LIVE_W-1:0] item_live;

	always_comb begin
		item_we     = 1'b0;
		item_wdata  = rd;
		free_next   = free_q;
		item_status = RES_OK;
		item_live   = '0;
		if (!in_range) begin
			item_status = RES_RANGE;
		end else begin
			case (op_q)
				OP_WRITE: begin
					item_we    = 1'b1;
					item_wdata = '{state: est_q, live: elive_q, wtime: etime_q};
					item_live  = elive_q;
					if (rd.state == SEG_FREE && est_q != SEG_FREE && free_q != '0) begin
						free_next = free_q - CNT_W'(1);
					end else if (rd.state != SEG_FREE && est_q == SEG_FREE) begin
						free_next = free_q + CNT_W'(1);
					end
				end
				OP_MARK: begin
					item_we = 1'b1;
					if (rd.live != '0) begin
						item_wdata.live = rd.live - LIVE_W'(1);
					end
					item_live = item_wdata.live;
				end
				OP_RELEASE: begin
					if (rd.state != SEG_FULL) begin
						item_status = RES_NOT_FULL;
						item_live   = rd.live;
					end else begin
						item_we          = 1'b1;
						item_wdata.state = SEG_FREE;
						item_wdata.live  = '0;
						free_next        = free_q + CNT_W'(1);
					end
				end
				default: begin
					item_we = 1'b0;
				end
			endcase
		end
	end

	// Write port: clearing pass or item write-back.
	always_comb begin
		if (cmd.clr_step) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = '0;
		end else begin
			ram_we    = cmd.item_wb && item_we;
			ram_waddr = item_addr;
			ram_wdata = item_wdata;
		end
	end

	// Scan stage one: candidate filter, age and first products.
	logic              ok_s1, ok_s2;
	logic [LIVE_W-1:0] live_s1;
	logic [AGE_W-1:0]  age_s1, age_c;
	logic [P1_W-1:0]   p1_s1, q1_s1;
	logic [P2_W-1:0]   lhs_s2, rhs_s2;
	logic [PW-1:0]     live_pct, lim_pct;
	logic              have_q;
	logic [SEG_AW-1:0] best_idx_q;
	logic [LIVE_W-1:0] best_live_q;
	logic [AGE_W-1:0]  best_age_q;

	assign age_c    = now_q - rd.wtime;
	assign live_pct = PW'(rd.live) * PW'(100);
	assign lim_pct  = (PW'(maxp_q) + PW'(1)) * PW'(LIVE_MAX);

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			ok_s1   <= (rd.state == SEG_FULL) && (live_pct < lim_pct) && (rd.live < LIVE_MAX);
			live_s1 <= rd.live;
			age_s1  <= age_c;
			p1_s1   <= P1_W'(age_c) * P1_W'(LIVE_MAX - rd.live);
			q1_s1   <= P1_W'(best_age_q) * P1_W'(LIVE_MAX - best_live_q);
		end
	end

	// Scan stage two: second products of the cross comparison.
	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			ok_s2  <= ok_s1;
			lhs_s2 <= P2_W'(p1_s1) * P2_W'({1'b0, LIVE_MAX} + {1'b0, best_live_q});
			rhs_s2 <= P2_W'(q1_s1) * P2_W'({1'b0, LIVE_MAX} + {1'b0, live_s1});
		end
	end

	// Best candidate so far; ties keep the lower index. A new segment count
	// drops any earlier choice.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			scan_idx_q <= '0;
		end else if (cmd.load || cfg_clear) begin
			have_q     <= 1'b0;
			scan_idx_q <= '0;
		end else if (cmd.cmp) begin
			scan_idx_q <= scan_idx_q + SEG_AW'(1);
			if (ok_s2 && (!have_q || lhs_s2 > rhs_s2)) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp && ok_s2 && (!have_q || lhs_s2 > rhs_s2)) begin
			best_idx_q  <= scan_idx_q;
			best_live_q <= live_s1;
			best_age_q  <= age_s1;
		end
	end

	// Configuration registers and free counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segs_q <= CNT_W'(1024);
			low_q  <= PCT_W'(10);
			maxp_q <= PCT_W'(50);
			free_q <= clamp_cnt(CNT_W'(1024));
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEGS: begin
					segs_q <= cfg_data;
					free_q <= clamp_cnt(cfg_data);
				end
				REG_LOW_FREE: low_q  <= cfg_data[PCT_W-1:0];
				REG_MAX_LIVE: maxp_q <= cfg_data[PCT_W-1:0];
				default:      segs_q <= segs_q;
			endcase
		end else if (cmd.item_wb) begin
			free_q <= free_next;
		end
	end

	// Low free space flag: free*100/cnt < low, rewritten without a divide.
	logic gc_c;
	assign gc_c = (GW'(free_next) * GW'(100)) < (GW'(low_q) * GW'(cnt));

	// Result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.item_wb || cmd.scan_done;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_wb) begin
			status         <= item_status;
			victim_valid   <= 1'b0;
			victim_segment <= '0;
			gc_needed      <= gc_c;
			free_count     <= free_next;
			live_after     <= item_live;
		end else if (cmd.scan_done) begin
			status         <= RES_OK;
			victim_valid   <= have_q;
			victim_segment <= have_q ? best_idx_q : '0;
			gc_needed      <= gc_c;
			free_count     <= free_q;
			live_after     <= have_q ? best_live_q : '0;
		end
	end

	// Checks on the result word and the running best candidate.
	logic victim_ok, best_ok, result_cmd;

	assign victim_ok  = (status == RES_OK) && (CNT_W'(victim_segment) < cnt);
	assign best_ok    = (CNT_W'(best_idx_q) < cnt) && (best_live_q < LIVE_MAX);
	assign result_cmd = cmd.item_wb || cmd.scan_done;

	`ASSERT_ALWAYS(a_free_bound, clk, arst_n, free_q <= cnt || cmd.clr_step, "free count too high")
	`ASSERT_IMPLY(a_victim_ok, clk, arst_n, done && victim_valid, victim_ok, "victim outside table")
	`ASSERT_IMPLY(a_best_range, clk, arst_n, have_q, best_ok, "best candidate invalid")
	`ASSERT_IMPLY(a_one_cmd, clk, arst_n, result_cmd, $past(!done) || !done, "results back to back")

endmodule
`default_nettype wire

@@ design/lfs_segment_cleaner_table.sv @@
// Channel    Handshake         Words
// command    start / busy      op, segment, block_addr, entry_state, entry_live,
//                              entry_time, now
// result     done (1 cycle)    status, victim_valid, victim_segment, gc_needed,
//                              free_count, live_after
// config     cfg_we            cfg_index, cfg_data
//
// Write, mark dead and release go from start to done through a read, a write-back
// and the registered result, bound by the registered read of the table memory.
// Victim selection walks the segments in use one entry at a time: each entry is
// read, goes through two multiply stages and one compare.
// After reset and after every write of segments_in_use a clearing pass over every
// table entry resets the table; busy stays high while it runs.
// The receiver cannot stall; each result word is shown for one cycle.
`default_nettype none
module lfs_segment_cleaner_table
	import lsct_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        op,
	input  wire logic [SEG_AW-1:0] segment,
	input  wire logic [BLK_W-1:0]  block_addr,
	input  wire logic [1:0]        entry_state,
	input  wire logic [LIVE_W-1:0] entry_live,
	input  wire logic [TIME_W-1:0] entry_time,
	input  wire logic [TIME_W-1:0] now,
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [CNT_W-1:0]  cfg_data,
	output logic                   done,
	output logic [1:0]             status,
	output logic                   victim_valid,
	output logic [SEG_AW-1:0]      victim_segment,
	output logic                   gc_needed,
	output logic [CNT_W-1:0]       free_count,
	output logic [LIVE_W-1:0]      live_after
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	lsct_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.op    (op),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	// Table, scan arithmetic and result word.
	lsct_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.op            (op),
		.segment       (segment),
		.block_addr    (block_addr),
		.entry_state   (entry_state),
		.entry_live    (entry_live),
		.entry_time    (entry_time),
		.now           (now),
		.done          (done),
		.status        (status),
		.victim_valid  (victim_valid),
		.victim_segment(victim_segment),
		.gc_needed     (gc_needed),
		.free_count    (free_count),
		.live_after    (live_after)
	);

endmodule
`default_nettype wire
